// ===== design/srfa_pkg.sv =====
// Shared types, constants and field layout for the shared resource arbiter.
`default_nettype none
package srfa_pkg;

  // Consumer count and derived widths
  localparam int CONSUMERS = 32;
  localparam int ID_W      = 5;
  localparam int TBL_AW    = (CONSUMERS > 1) ? $clog2(CONSUMERS) : 1;
  localparam int QDEPTH    = 32;
  localparam int Q_AW      = 5;
  localparam int ADDR_W    = 32;
  localparam int CNT_W     = 32;

  // Stream payload widths; the tdata widths are padded to whole bytes
  localparam int IN_TDATA_W  = 72;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 88;

  // Input tdata field offsets
  localparam int IN_ID_LSB   = 0;
  localparam int IN_ADDR_LSB = IN_ID_LSB + ID_W;
  localparam int IN_CNT_LSB  = IN_ADDR_LSB + ADDR_W;

  typedef enum logic [1:0] {
    OP_ATTACH   = 2'd0,
    OP_DETACH   = 2'd1,
    OP_REQUEST  = 2'd2,
    OP_COMPLETE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_ID   = 2'd1,
    ST_PENDING = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  // Classified command handed from front to back
  typedef struct packed {
    op_e               op;
    logic [ID_W-1:0]   id;
    logic              id_ok;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  cnt;
  } cmd_t;

  // One result item
  typedef struct packed {
    status_e           status;
    logic [ID_W-1:0]   assigned_id;
    logic              power_up;
    logic              power_down;
    logic              start_valid;
    logic [ID_W-1:0]   start_id;
    logic [ADDR_W-1:0] start_address;
    logic [CNT_W-1:0]  start_count;
    logic              completed_valid;
    logic [ID_W-1:0]   completed_id;
  } res_t;

endpackage
`default_nettype wire

// ===== design/shared_resource_fifo_arbiter.sv =====
// Top level: shared engine arbiter with consumer id allocator.
//
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid_i/tready_o      tuser operation, tdata id/addr/count
//  m_axis    out        m_axis_tvalid_o/tready_i      tdata result item
//
//  An item is registered in the front queue; the back end pops it and loads
//  its result into the output register at the same edge, so attach, detach,
//  request and idle completion sustain one item per cycle while the output
//  register is free. A completion that starts a queued request goes through
//  the queue read and table read states, set by the dependent registered reads of
//  the wait queue and then the request tables. Reset clears the masks, the
//  queue pointers and all handshake state; the memories are not cleared. The
//  front queue keeps accepting while a result waits, until its two entries fill.
`default_nettype none
module shared_resource_fifo_arbiter (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // consumer_id[4:0], buffer_address[36:5], word_count[68:37], zero fill
  input  wire logic [srfa_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // operation[1:0]
  input  wire logic [srfa_pkg::IN_TUSER_W-1:0]  s_axis_tuser_i,
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // status[1:0], assigned_id[6:2], engine_power_up[7], engine_power_down[8],
  // start_valid[9], start_id[14:10], start_address[46:15], start_count[78:47],
  // completed_valid[79], completed_id[84:80], zero fill
  output logic [srfa_pkg::OUT_TDATA_W-1:0]      m_axis_tdata_o
);
  import srfa_pkg::*;

  logic cmd_valid, cmd_pop;
  cmd_t cmd;
  res_t res;

  srfa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_tdata_i  (s_axis_tdata_i),
    .in_tuser_i  (s_axis_tuser_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  srfa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (res)
  );

  // Pack the result item, first field lowest
  assign m_axis_tdata_o = {3'b000, res.completed_id, res.completed_valid, res.start_count,
                           res.start_address, res.start_id, res.start_valid,
                           res.power_down, res.power_up, res.assigned_id, res.status};

endmodule
`default_nettype wire

// ===== design/srfa_front.sv =====
// Front end: accepts input items, classifies them and buffers them in a short queue.
`default_nettype none
module srfa_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [srfa_pkg::IN_TDATA_W-1:0] in_tdata_i,
  input  wire logic [srfa_pkg::IN_TUSER_W-1:0] in_tuser_i,
  output logic                                 cmd_valid_o,
  output srfa_pkg::cmd_t                       cmd_o,
  input  wire logic                            cmd_pop_i
);
  import srfa_pkg::*;

  localparam int QD = 2;

  cmd_t       slot_q [QD];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  cmd_t       cmd_in;
  logic       push, pop;

  // Classify the incoming item
  always_comb begin
    cmd_in.op    = op_e'(in_tuser_i);
    cmd_in.id    = in_tdata_i[IN_ID_LSB +: ID_W];
    cmd_in.id_ok = (int'(in_tdata_i[IN_ID_LSB +: ID_W]) < CONSUMERS);
    cmd_in.addr  = in_tdata_i[IN_ADDR_LSB +: ADDR_W];
    cmd_in.cnt   = in_tdata_i[IN_CNT_LSB +: CNT_W];
  end

  assign in_ready_o  = (count_q != 2'(QD));
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  // Advance queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop)      count_q <= count_q + 2'd1;
      else if (pop && !push) count_q <= count_q - 2'd1;
    end
  end

  // Hold queued commands
  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= cmd_in;
  end

endmodule
`default_nettype wire

// ===== design/srfa_back.sv =====
// Back end: consumer masks, wait queue, request tables and result register.
`default_nettype none
module srfa_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_valid_i,
  input  wire srfa_pkg::cmd_t cmd_i,
  output logic                cmd_pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output srfa_pkg::res_t      out_o
);
  import srfa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_QRD,
    S_TRD
  } state_e;

  state_e                state_q, state_d;
  logic [CONSUMERS-1:0]  attached_q, attached_d;
  logic [CONSUMERS-1:0]  pending_q, pending_d;
  logic                  busy_q, busy_d;
  logic [ID_W-1:0]       active_q, active_d;
  logic [Q_AW-1:0]       head_q, head_d;
  logic [Q_AW-1:0]       tail_q, tail_d;
  logic [ID_W-1:0]       nxt_q, nxt_d;
  logic                  out_valid_q;
  res_t                  out_q;

  // Memories and their registered read data
  logic [ID_W-1:0]       wait_mem [QDEPTH];
  logic [ADDR_W-1:0]     addr_mem [CONSUMERS];
  logic [CNT_W-1:0]      cnt_mem  [CONSUMERS];
  logic [ID_W-1:0]       fifo_rd_q;
  logic [ADDR_W-1:0]     addr_rd_q;
  logic [CNT_W-1:0]      cnt_rd_q;
  logic [TBL_AW-1:0]     tbl_raddr;

  logic                  out_free, out_load;
  res_t                  res;
  logic                  tbl_we, q_we;
  logic [TBL_AW-1:0]     cidx;
  logic                  known, dup;
  logic                  free_found;
  logic [TBL_AW-1:0]     free_idx;

  // Find the lowest free consumer id
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int k = CONSUMERS - 1; k >= 0; k--) begin
      if (!attached_q[k]) begin
        free_found = 1'b1;
        free_idx   = TBL_AW'(k);
      end
    end
  end

  assign cidx      = cmd_i.id[TBL_AW-1:0];
  assign known     = cmd_i.id_ok && attached_q[cidx];
  assign dup       = (busy_q && (active_q == cmd_i.id)) || pending_q[cidx];
  assign out_free  = !out_valid_q || out_ready_i;
  assign tbl_raddr = (state_q == S_QRD) ? fifo_rd_q[TBL_AW-1:0] : nxt_q[TBL_AW-1:0];

  // Execute one command and build its result
  always_comb begin
    state_d    = state_q;
    attached_d = attached_q;
    pending_d  = pending_q;
    busy_d     = busy_q;
    active_d   = active_q;
    head_d     = head_q;
    tail_d     = tail_q;
    nxt_d      = nxt_q;
    res        = '0;
    cmd_pop_o  = 1'b0;
    out_load   = 1'b0;
    tbl_we     = 1'b0;
    q_we       = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          case (cmd_i.op)
            OP_ATTACH: begin
              cmd_pop_o = 1'b1;
              out_load  = 1'b1;
              // first attach empties the queue and idles the engine
              if (attached_q == '0) begin
                head_d    = '0;
                tail_d    = '0;
                pending_d = '0;
                busy_d    = 1'b0;
                active_d  = '0;
              end
              if (!free_found) begin
                res.status = ST_NO_ID;
              end else begin
                res.status            = ST_OK;
                res.assigned_id       = ID_W'(free_idx);
                res.power_up          = (attached_q == '0);
                attached_d[free_idx]  = 1'b1;
              end
            end
            OP_DETACH: begin
              cmd_pop_o = 1'b1;
              out_load  = 1'b1;
              if (!known) begin
                res.status = ST_INVALID;
              end else begin
                attached_d[cidx] = 1'b0;
                res.status       = ST_OK;
                res.power_down   = (attached_d == '0);
              end
            end
            OP_REQUEST: begin
              cmd_pop_o = 1'b1;
              out_load  = 1'b1;
              if (!known) begin
                res.status = ST_INVALID;
              end else if (dup) begin
                res.status = ST_PENDING;
              end else begin
                tbl_we     = 1'b1;
                res.status = ST_OK;
                if (!busy_q) begin
                  busy_d            = 1'b1;
                  active_d          = cmd_i.id;
                  res.start_valid   = 1'b1;
                  res.start_id      = cmd_i.id;
                  res.start_address = cmd_i.addr;
                  res.start_count   = cmd_i.cnt;
                end else begin
                  q_we            = 1'b1;
                  tail_d          = tail_q + Q_AW'(1);
                  pending_d[cidx] = 1'b1;
                end
              end
            end
            OP_COMPLETE: begin
              if (!busy_q) begin
                cmd_pop_o  = 1'b1;
                out_load   = 1'b1;
                res.status = ST_INVALID;
              end else if (head_q != tail_q) begin
                // fetch the oldest waiting id, then its table entry
                state_d = S_QRD;
              end else begin
                cmd_pop_o           = 1'b1;
                out_load            = 1'b1;
                res.status          = ST_OK;
                res.completed_valid = 1'b1;
                res.completed_id    = active_q;
                busy_d              = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      S_QRD: begin
        nxt_d   = fifo_rd_q;
        state_d = S_TRD;
      end
      S_TRD: begin
        if (out_free) begin
          cmd_pop_o                       = 1'b1;
          out_load                        = 1'b1;
          res.status                      = ST_OK;
          res.completed_valid             = 1'b1;
          res.completed_id                = active_q;
          res.start_valid                 = 1'b1;
          res.start_id                    = nxt_q;
          res.start_address               = addr_rd_q;
          res.start_count                 = cnt_rd_q;
          active_d                        = nxt_q;
          head_d                          = head_q + Q_AW'(1);
          pending_d[nxt_q[TBL_AW-1:0]]    = 1'b0;
          state_d                         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      attached_q  <= '0;
      pending_q   <= '0;
      busy_q      <= 1'b0;
      active_q    <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      nxt_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q    <= state_d;
      attached_q <= attached_d;
      pending_q  <= pending_d;
      busy_q     <= busy_d;
      active_q   <= active_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      nxt_q      <= nxt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_q       <= res;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Wait queue: write at tail, registered read at head
  always_ff @(posedge clk_i) begin
    if (q_we) wait_mem[tail_q] <= cmd_i.id;
    fifo_rd_q <= wait_mem[head_q];
  end

  // Request tables: write on accepted request, registered read of next id
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      addr_mem[cidx] <= cmd_i.addr;
      cnt_mem[cidx]  <= cmd_i.cnt;
    end
    addr_rd_q <= addr_mem[tbl_raddr];
    cnt_rd_q  <= cnt_mem[tbl_raddr];
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTHESIS
  // An idle engine has nothing queued
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (pending_q == '0) && (head_q == tail_q))
    else $error("idle engine with queued requests");

  // Queue occupancy matches the pending mask
  a_pending_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(pending_q) == int'(Q_AW'(tail_q - head_q)))
    else $error("pending mask and queue occupancy disagree");

  // Queue fetch only runs with a busy engine and a non-empty queue
  a_fetch_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_QRD) |-> busy_q && (head_q != tail_q))
    else $error("queue fetch without waiting request");

  // Queue fetch is followed by the table read stage
  a_fetch_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_QRD) |=> (state_q == S_TRD))
    else $error("queue fetch not followed by table read");
`endif

endmodule
`default_nettype wire

// ===== tb/srfa_checker.sv =====
// Stream monitor and scoreboard for the shared resource arbiter: predicts and checks each result.
module srfa_checker (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_tvalid_i,
  input  wire logic                             in_tready_i,
  // consumer_id[4:0], buffer_address[36:5], word_count[68:37], zero fill
  input  wire logic [srfa_pkg::IN_TDATA_W-1:0]  in_tdata_i,
  // operation[1:0]
  input  wire logic [srfa_pkg::IN_TUSER_W-1:0]  in_tuser_i,
  input  wire logic                             out_tvalid_i,
  input  wire logic                             out_tready_i,
  // status[1:0], assigned_id[6:2], engine_power_up[7], engine_power_down[8],
  // start_valid[9], start_id[14:10], start_address[46:15], start_count[78:47],
  // completed_valid[79], completed_id[84:80], zero fill
  input  wire logic [srfa_pkg::OUT_TDATA_W-1:0] out_tdata_i,
  output int                                    fail_count_o,
  output int                                    outstanding_o,
  output int                                    checked_o,
  output int                                    no_id_seen_o
);
  import srfa_pkg::*;

  // Shadow of the arbiter state
  logic [CONSUMERS-1:0] attached_q;
  logic [CONSUMERS-1:0] pending_q;
  logic                 busy_q;
  logic [ID_W-1:0]      active_q;
  logic [ID_W-1:0]      wait_ids [QDEPTH];
  logic [Q_AW-1:0]      head_q;
  logic [Q_AW-1:0]      tail_q;
  logic [ADDR_W-1:0]    addr_tbl [CONSUMERS];
  logic [CNT_W-1:0]     cnt_tbl  [CONSUMERS];

  // Results still owed by the block, oldest first
  res_t owed_results [$];

  // Fill in the start fields for the request of one consumer
  function automatic res_t with_start(res_t r, logic [ID_W-1:0] id);
    r.start_valid   = 1'b1;
    r.start_id      = id;
    r.start_address = addr_tbl[id];
    r.start_count   = cnt_tbl[id];
    return r;
  endfunction

  // Advance the shadow state by one command and return the result it causes
  function automatic res_t arbitrate(op_e op, logic [ID_W-1:0] id,
                                     logic [ADDR_W-1:0] addr, logic [CNT_W-1:0] cnt);
    res_t r;
    logic known;
    int   free_id;
    r       = '0;
    r.status = ST_OK;
    known   = (int'(id) < CONSUMERS) && attached_q[id];
    free_id = -1;
    case (op)
      OP_ATTACH: begin
        // first attach drops any leftover queue and engine state
        if (attached_q == '0) begin
          head_q    = '0;
          tail_q    = '0;
          pending_q = '0;
          busy_q    = 1'b0;
          active_q  = '0;
        end
        for (int k = CONSUMERS - 1; k >= 0; k--) begin
          if (!attached_q[k]) free_id = k;
        end
        if (free_id < 0) begin
          r.status = ST_NO_ID;
        end else begin
          r.power_up          = (attached_q == '0);
          attached_q[free_id] = 1'b1;
          r.assigned_id       = free_id[ID_W-1:0];
        end
      end
      OP_DETACH: begin
        if (!known) begin
          r.status = ST_INVALID;
        end else begin
          attached_q[id] = 1'b0;
          r.power_down   = (attached_q == '0);
        end
      end
      OP_REQUEST: begin
        if (!known) begin
          r.status = ST_INVALID;
        end else if ((busy_q && active_q == id) || pending_q[id]) begin
          r.status = ST_PENDING;
        end else begin
          addr_tbl[id] = addr;
          cnt_tbl[id]  = cnt;
          if (!busy_q) begin
            busy_q   = 1'b1;
            active_q = id;
            r        = with_start(r, id);
          end else begin
            wait_ids[tail_q] = id;
            tail_q           = tail_q + Q_AW'(1);
            pending_q[id]    = 1'b1;
          end
        end
      end
      default: begin
        if (!busy_q) begin
          r.status = ST_INVALID;
        end else begin
          r.completed_valid = 1'b1;
          r.completed_id    = active_q;
          // hand the engine to the oldest waiting consumer, if any
          if (head_q != tail_q) begin
            active_q                  = wait_ids[head_q];
            head_q                    = head_q + Q_AW'(1);
            pending_q[active_q]       = 1'b0;
            r                         = with_start(r, active_q);
          end else begin
            busy_q = 1'b0;
          end
        end
      end
    endcase
    return r;
  endfunction

  // Report one field that differs from its expectation
  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_count_o++;
      $display("%0t mismatch in %s: expected %h actual %h", $time, name, want, got);
    end
  endtask

  // Watch both channels: check results first, then queue the new expectation
  always @(posedge clk_i or negedge rst_ni) begin
    res_t got;
    res_t want;
    if (!rst_ni) begin
      attached_q    = '0;
      pending_q     = '0;
      busy_q        = 1'b0;
      active_q      = '0;
      head_q        = '0;
      tail_q        = '0;
      owed_results.delete();
      fail_count_o  = 0;
      outstanding_o = 0;
      checked_o     = 0;
      no_id_seen_o  = 0;
    end else begin
      if (out_tvalid_i && out_tready_i) begin
        got.status          = status_e'(out_tdata_i[1:0]);
        got.assigned_id     = out_tdata_i[6:2];
        got.power_up        = out_tdata_i[7];
        got.power_down      = out_tdata_i[8];
        got.start_valid     = out_tdata_i[9];
        got.start_id        = out_tdata_i[14:10];
        got.start_address   = out_tdata_i[46:15];
        got.start_count     = out_tdata_i[78:47];
        got.completed_valid = out_tdata_i[79];
        got.completed_id    = out_tdata_i[84:80];
        if (owed_results.size() == 0) begin
          fail_count_o++;
          $display("%0t unexpected result item: expected none actual %h", $time, out_tdata_i);
        end else begin
          want = owed_results.pop_front();
          checked_o++;
          if (want.status == ST_NO_ID) no_id_seen_o++;
          compare_field("status", 32'(want.status), 32'(got.status));
          compare_field("assigned_id", 32'(want.assigned_id), 32'(got.assigned_id));
          compare_field("engine_power_up", 32'(want.power_up), 32'(got.power_up));
          compare_field("engine_power_down", 32'(want.power_down), 32'(got.power_down));
          compare_field("start_valid", 32'(want.start_valid), 32'(got.start_valid));
          compare_field("start_id", 32'(want.start_id), 32'(got.start_id));
          compare_field("start_address", want.start_address, got.start_address);
          compare_field("start_count", want.start_count, got.start_count);
          compare_field("completed_valid", 32'(want.completed_valid),
                        32'(got.completed_valid));
          compare_field("completed_id", 32'(want.completed_id), 32'(got.completed_id));
        end
      end
      if (in_tvalid_i && in_tready_i) begin
        owed_results.push_back(arbitrate(op_e'(in_tuser_i[1:0]),
                                         in_tdata_i[IN_ID_LSB +: ID_W],
                                         in_tdata_i[IN_ADDR_LSB +: ADDR_W],
                                         in_tdata_i[IN_CNT_LSB +: CNT_W]));
      end
      outstanding_o = owed_results.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the arbiter testbench: clock, reset, item stimulus, output stalls and verdict.
module testbench;
  import srfa_pkg::*;

  localparam int RANDOM_ITEMS   = 1100;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;

  logic                   clk      = 1'b0;
  logic                   rst_n    = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic [IN_TUSER_W-1:0]  s_tuser  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  int fail_count;
  int outstanding;
  int checked;
  int no_id_seen;
  int items_sent    = 0;
  int directed_sent = 0;
  int idle_phase    = 0;
  int stall_cycles  = 0;
  bit hold_done     = 1'b0;

  shared_resource_fifo_arbiter DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  srfa_checker checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_tvalid_i   (s_tvalid),
    .in_tready_i   (s_tready),
    .in_tdata_i    (s_tdata),
    .in_tuser_i    (s_tuser),
    .out_tvalid_i  (m_tvalid),
    .out_tready_i  (m_tready),
    .out_tdata_i   (m_tdata),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding),
    .checked_o     (checked),
    .no_id_seen_o  (no_id_seen)
  );

  // Clock and a single reset pulse
  always #5 clk = ~clk;

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Mostly random words, with the extremes now and then
  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Offer one item, idling first as the current phase asks, and hold until taken
  task automatic send_item(op_e op, logic [ID_W-1:0] id, logic [31:0] addr, logic [31:0] cnt);
    while ($urandom_range(99) < ((idle_phase == 0) ? 26 : (idle_phase == 1) ? 47 : 0)) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {3'b000, cnt, addr, id};
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // Receiver: random stalls per phase, plus one long hold-off once stalls stop
  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      if (idle_phase == 2 && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        while (stall_cycles < HOLD_CYCLES) begin
          @(posedge clk);
          stall_cycles++;
        end
      end else begin
        m_tready <= ($urandom_range(99) >= ((idle_phase == 0) ? 47 :
                                            (idle_phase == 1) ? 26 : 0));
        @(posedge clk);
      end
    end
  end

  // Watchdog: give up when nothing moves for too long
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no item moved for %0d cycles", $time, quiet_cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Stimulus and verdict
  initial begin
    int              mode;
    int              span;
    int              burst_len;
    int              roll;
    logic [ID_W-1:0] sweep_id;
    logic [ID_W-1:0] id;
    op_e             op;
    sweep_id = '0;
    while (!rst_n) @(posedge clk);

    // Directed: allocation, start, duplicates, queueing, teardown and misuse
    send_item(OP_ATTACH,   5'd31, '1, '1);             // power up, id 0
    send_item(OP_ATTACH,   5'd0,  '0, '0);             // id 1
    send_item(OP_REQUEST,  5'd0,  32'hFFFF_FFFF, 32'h0);  // starts at once
    send_item(OP_REQUEST,  5'd0,  32'h1234_5678, 32'h9);  // already active
    send_item(OP_REQUEST,  5'd1,  32'h0, 32'hFFFF_FFFF);  // joins the queue
    send_item(OP_REQUEST,  5'd1,  32'h0, 32'h1);          // already queued
    send_item(OP_DETACH,   5'd1,  '0, '0);             // detach with work queued
    send_item(OP_COMPLETE, 5'd17, '0, '0);             // finish 0, start 1
    send_item(OP_COMPLETE, 5'd0,  '0, '0);             // finish 1, engine idle
    send_item(OP_COMPLETE, 5'd0,  '0, '0);             // completion while idle
    send_item(OP_DETACH,   5'd31, '0, '0);             // not attached
    send_item(OP_REQUEST,  5'd31, '1, '1);             // not attached
    send_item(OP_DETACH,   5'd0,  '0, '0);             // last detach, power down
    send_item(OP_DETACH,   5'd0,  '0, '0);             // detach twice
    send_item(OP_ATTACH,   5'd0,  '0, '0);             // power up again
    send_item(OP_REQUEST,  5'd0,  32'hAAAA_AAAA, 32'h5555_5555);
    send_item(OP_ATTACH,   5'd0,  '0, '0);
    send_item(OP_REQUEST,  5'd1,  32'h5555_5555, 32'hAAAA_AAAA);
    send_item(OP_DETACH,   5'd0,  '0, '0);
    send_item(OP_DETACH,   5'd1,  '0, '0);             // power down with engine busy
    send_item(OP_ATTACH,   5'd21, '0, '0);             // first attach drops stale work
    send_item(OP_COMPLETE, 5'd10, '0, '0);             // engine now idle
    send_item(OP_DETACH,   5'd0,  '0, '0);
    directed_sent = items_sent;

    // Random bursts: busy traffic on 2 to 32 ids, filling all ids, sweeping teardown
    while (items_sent - directed_sent < RANDOM_ITEMS) begin
      mode      = $urandom_range(9);
      burst_len = $urandom_range(100, 40);
      span      = (2 << $urandom_range(4)) - 1;
      repeat (burst_len) begin
        roll = $urandom_range(99);
        id   = ID_W'($urandom_range(span));
        if (mode < 6) begin
          op = (roll < 12) ? OP_ATTACH : (roll < 20) ? OP_DETACH :
               (roll < 62) ? OP_REQUEST : OP_COMPLETE;
        end else if (mode < 8) begin
          op = (roll < 65) ? OP_ATTACH : (roll < 85) ? OP_REQUEST : OP_COMPLETE;
          id = ID_W'($urandom_range(31));
        end else begin
          op = (roll < 55) ? OP_DETACH : (roll < 80) ? OP_COMPLETE : OP_REQUEST;
          if (op == OP_DETACH) begin
            id       = sweep_id;
            sweep_id = sweep_id + ID_W'(1);
          end
        end
        send_item(op, id, pick_word(), pick_word());
        idle_phase = (items_sent - directed_sent < 370) ? 0 :
                     (items_sent - directed_sent < 740) ? 1 : 2;
      end
    end
    s_tvalid <= 1'b0;

    // Drain: wait for every owed result, then give the block time to misbehave
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d items (%0d directed) over two stall mixes, a stall-free stretch",
             items_sent, directed_sent);
    $display("and a %0d-cycle output hold-off; %0d results checked, %0d with all ids taken",
             stall_cycles, checked, no_id_seen);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
